### hw/rtl/ps2s1_pkg.sv
// Shared types, byte constants and key tables for the set 1 scan code decoder.
package ps2s1_pkg;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [7:0] BYTE_E0 = 8'hE0;
  localparam logic [7:0] BYTE_E1 = 8'hE1;
  localparam logic [7:0] BYTE_2A = 8'h2A;
  localparam logic [7:0] BYTE_B7 = 8'hB7;
  localparam logic [7:0] BYTE_37 = 8'h37;
  localparam logic [7:0] BYTE_AA = 8'hAA;
  localparam logic [7:0] BYTE_1D = 8'h1D;
  localparam logic [7:0] BYTE_45 = 8'h45;
  localparam logic [7:0] BYTE_9D = 8'h9D;
  localparam logic [7:0] BYTE_C5 = 8'hC5;

  localparam logic [6:0] CODE_UNKNOWN      = 7'd0;
  localparam logic [6:0] CODE_PRINT_SCREEN = 7'd124;
  localparam logic [6:0] CODE_PAUSE        = 7'd125;

  typedef enum logic [3:0] {
    ST_NORMAL    = 4'd0,
    ST_E0        = 4'd1,
    ST_PRTSC_1   = 4'd2,
    ST_E0_REPEAT = 4'd3,
    ST_E1        = 4'd4,
    ST_PAUSE_1   = 4'd5,
    ST_PAUSE_2   = 4'd6,
    ST_E1_REPEAT = 4'd7,
    ST_PAUSE_3   = 4'd8
  } prefix_state_t;

  typedef struct packed {
    logic [6:0] key_code;
    logic       released;
    logic       last;
  } key_event_t;

  typedef struct packed {
    logic [1:0] cnt;
    key_event_t ev0;
    key_event_t ev1;
  } dec_res_t;

  function automatic logic [6:0] plain_code(input logic [6:0] idx);
    logic [6:0] code;
    code = CODE_UNKNOWN;
    if (idx inside {[7'h01:7'h53]}) begin
      code = idx;
    end else if (idx == 7'h57) begin
      code = 7'd84;
    end else if (idx == 7'h58) begin
      code = 7'd85;
    end
    return code;
  endfunction

  function automatic logic [6:0] ext_code(input logic [6:0] idx);
    logic [6:0] code;
    case (idx)
      7'h10: code = 7'd86;
      7'h19: code = 7'd87;
      7'h1C: code = 7'd88;
      7'h1D: code = 7'd89;
      7'h20: code = 7'd90;
      7'h21: code = 7'd91;
      7'h22: code = 7'd92;
      7'h24: code = 7'd93;
      7'h2E: code = 7'd94;
      7'h30: code = 7'd95;
      7'h32: code = 7'd96;
      7'h35: code = 7'd97;
      7'h38: code = 7'd98;
      7'h47: code = 7'd99;
      7'h48: code = 7'd100;
      7'h49: code = 7'd101;
      7'h4B: code = 7'd102;
      7'h4D: code = 7'd103;
      7'h4F: code = 7'd104;
      7'h50: code = 7'd105;
      7'h51: code = 7'd106;
      7'h52: code = 7'd107;
      7'h53: code = 7'd108;
      7'h5B: code = 7'd109;
      7'h5C: code = 7'd110;
      7'h5D: code = 7'd111;
      7'h5E: code = 7'd112;
      7'h5F: code = 7'd113;
      7'h63: code = 7'd114;
      7'h65: code = 7'd115;
      7'h66: code = 7'd116;
      7'h67: code = 7'd117;
      7'h68: code = 7'd118;
      7'h69: code = 7'd119;
      7'h6A: code = 7'd120;
      7'h6B: code = 7'd121;
      7'h6C: code = 7'd122;
      7'h6D: code = 7'd123;
      default: code = CODE_UNKNOWN;
    endcase
    return code;
  endfunction

endpackage

### hw/rtl/ps2s1_decode.sv
// Prefix state machine and key event decode for one scan code byte.
module ps2s1_decode
  import ps2s1_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic [7:0] scan_byte,
  output dec_res_t   res
);

  prefix_state_t state_r;
  prefix_state_t state_nxt;
  logic          rel;
  logic [6:0]    idx;

  assign rel = scan_byte[7];
  assign idx = scan_byte[6:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_E0: begin
        if (scan_byte == BYTE_2A || scan_byte == BYTE_B7) begin
          state_nxt = ST_PRTSC_1;
        end else begin
          state_nxt = ST_NORMAL;
        end
      end
      ST_PRTSC_1: begin
        if (scan_byte == BYTE_E0) begin
          state_nxt = ST_E0_REPEAT;
        end else begin
          state_nxt = ST_NORMAL;
        end
      end
      ST_E0_REPEAT: state_nxt = ST_NORMAL;
      ST_E1: begin
        if (scan_byte == BYTE_1D) begin
          state_nxt = ST_PAUSE_1;
        end
      end
      ST_PAUSE_1: begin
        if (scan_byte == BYTE_45) begin
          state_nxt = ST_PAUSE_2;
        end
      end
      ST_PAUSE_2: begin
        if (scan_byte == BYTE_E1) begin
          state_nxt = ST_E1_REPEAT;
        end
      end
      ST_E1_REPEAT: begin
        if (scan_byte == BYTE_9D) begin
          state_nxt = ST_PAUSE_3;
        end
      end
      ST_PAUSE_3: state_nxt = ST_NORMAL;
      default: begin
        if (scan_byte == BYTE_E0) begin
          state_nxt = ST_E0;
        end else if (scan_byte == BYTE_E1) begin
          state_nxt = ST_E1;
        end else begin
          state_nxt = ST_NORMAL;
        end
      end
    endcase
  end

  always_comb begin
    res     = '0;
    res.ev0 = '{key_code: CODE_UNKNOWN, released: rel, last: 1'b1};
    res.ev1 = '{key_code: CODE_PAUSE, released: 1'b1, last: 1'b1};
    case (state_r)
      ST_E0: begin
        if (!(scan_byte == BYTE_2A || scan_byte == BYTE_B7)) begin
          res.cnt          = 2'd1;
          res.ev0.key_code = ext_code(idx);
        end
      end
      ST_PRTSC_1: begin
        if (scan_byte != BYTE_E0) begin
          res.cnt          = 2'd1;
          res.ev0.key_code = plain_code(idx);
        end
      end
      ST_E0_REPEAT: begin
        if (scan_byte == BYTE_37 || scan_byte == BYTE_AA) begin
          res.cnt          = 2'd1;
          res.ev0.key_code = CODE_PRINT_SCREEN;
          res.ev0.released = (scan_byte == BYTE_AA);
        end
      end
      ST_E1, ST_PAUSE_1, ST_PAUSE_2, ST_E1_REPEAT: res.cnt = 2'd0;
      ST_PAUSE_3: begin
        if (scan_byte == BYTE_C5) begin
          res.cnt          = 2'd2;
          res.ev0.key_code = CODE_PAUSE;
          res.ev0.released = 1'b0;
          res.ev0.last     = 1'b0;
        end
      end
      default: begin
        if (scan_byte != BYTE_E0 && scan_byte != BYTE_E1) begin
          res.cnt          = 2'd1;
          res.ev0.key_code = plain_code(idx);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_NORMAL;
    end else if (fire) begin
      state_r <= state_nxt;
    end
  end

  // Every byte that yields an event leaves the prefix tracker with no prefix pending.
  a_event_clears_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res.cnt != 2'd0) |=> state_r == ST_NORMAL)
    else $error("prefix state not cleared after an event");

  a_two_events_only_pause: assert property (@(posedge clk) disable iff (!rst_n)
    (res.cnt == 2'd2) |-> (state_r == ST_PAUSE_3 && res.ev0.key_code == CODE_PAUSE))
    else $error("two events outside the pause sequence");

  a_hold_without_fire: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(state_r))
    else $error("prefix state moved without an item");

endmodule

### hw/rtl/ps2s1_outq.sv
// Small event queue that takes up to two key events per cycle and delivers one unless out_stall is high.
module ps2s1_outq
  import ps2s1_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] push_cnt,
  input  key_event_t push_ev0,
  input  key_event_t push_ev1,
  output logic       room,
  output logic       out_valid,
  input  logic       out_stall,
  output key_event_t out_ev
);

  key_event_t       q_r [QDepth];
  logic [QPtrW-1:0] wr_ptr_r;
  logic [QPtrW-1:0] wr_ptr_nxt;
  logic [QPtrW-1:0] wr_ptr_p1;
  logic [QPtrW-1:0] rd_ptr_r;
  logic [QPtrW-1:0] rd_ptr_nxt;
  logic [QCntW-1:0] count_r;
  logic [QCntW-1:0] count_nxt;
  logic             pop;

  assign room      = (count_r <= QCntW'(QDepth - 2));
  assign out_valid = (count_r != '0);
  assign out_ev    = q_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  assign wr_ptr_p1 = wr_ptr_r + QPtrW'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPtrW'(push_cnt);
    rd_ptr_nxt = pop ? rd_ptr_r + QPtrW'(1) : rd_ptr_r;
    count_nxt  = count_r + QCntW'(push_cnt) - QCntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      q_r[wr_ptr_r] <= push_ev0;
    end
    if (push_cnt == 2'd2) begin
      q_r[wr_ptr_p1] <= push_ev1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCntW'(QDepth))
    else $error("event queue overflow");

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push_cnt != 2'd0) |-> room)
    else $error("events pushed without room");

  a_ptr_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    QPtrW'(wr_ptr_r - rd_ptr_r) == count_r[QPtrW-1:0])
    else $error("queue pointers disagree with count");

endmodule

### hw/rtl/ps2_set1_scancode_decoder_top.sv
// Top level of the PS/2 scan code set 1 decoder.
//
// The input channel (in_valid, in_stall, in_scan_byte) takes one raw keyboard
// byte per item. The result channel (out_valid, out_stall, out_key_code,
// out_released, out_last) delivers key events; out_last marks the final event
// caused by one byte. Most bytes give one event, prefix bytes give none, and
// the last byte of the pause sequence gives a press and a release event.
// An accepted byte sits in an input register while the prefix state machine
// decodes it, and its events are written into a four-entry event queue.
// The first event is offered once the byte has passed the input register and
// been written into the queue; a queue without room holds it in the register.
// With the receiver taking events, one byte is accepted every cycle.
// When the receiver stalls, events collect in the queue; once the queue
// lacks space for two more events, the input register holds its byte and
// in_stall rises. Synchronous reset returns the prefix tracker to the state
// with no prefix seen and empties the input register and the queue.
module ps2_set1_scancode_decoder_top
  import ps2s1_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_scan_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] out_key_code,
  output logic       out_released,
  output logic       out_last
);

  logic       in_vld_r;
  logic       in_vld_nxt;
  logic [7:0] in_byte_r;
  logic       accept;
  logic       advance;
  logic       room;
  logic [1:0] push_cnt;
  dec_res_t   res;
  key_event_t out_ev;

  assign advance  = in_vld_r && room;
  assign in_stall = in_vld_r && !room;
  assign accept   = in_valid && !in_stall;
  assign push_cnt = advance ? res.cnt : 2'd0;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (accept) begin
      in_vld_nxt = 1'b1;
    end else if (advance) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_byte_r <= in_scan_byte;
    end
  end

  ps2s1_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (advance),
    .scan_byte (in_byte_r),
    .res       (res)
  );

  ps2s1_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .push_ev0  (res.ev0),
    .push_ev1  (res.ev1),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_ev    (out_ev)
  );

  assign out_key_code = out_ev.key_code;
  assign out_released = out_ev.released;
  assign out_last     = out_ev.last;

endmodule

### verif/tb_top.sv
// Self-checking testbench for the PS/2 scan code set 1 decoder top level.
module tb_top
  import ps2s1_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_ITEMS   = 670;

  class key_event_board;
    prefix_state_t pstate;
    key_event_t    pending_events[$];
    int            errors;

    function new();
      pstate = ST_NORMAL;
      errors = 0;
    endfunction

    function int pending();
      return pending_events.size();
    endfunction

    function logic [6:0] single_key(input logic [6:0] idx);
      if (idx >= 7'h01 && idx <= 7'h53) return idx;
      if (idx == 7'h57) return 7'd84;
      if (idx == 7'h58) return 7'd85;
      return CODE_UNKNOWN;
    endfunction

    function logic [6:0] extended_key(input logic [6:0] idx);
      if (idx >= 7'h50 && idx <= 7'h53) return idx - 7'h50 + 7'd105;
      if (idx >= 7'h5B && idx <= 7'h5F) return idx - 7'h5B + 7'd109;
      if (idx >= 7'h65 && idx <= 7'h6D) return idx - 7'h65 + 7'd115;
      case (idx)
        7'h10: return 7'd86;
        7'h19: return 7'd87;
        7'h1C: return 7'd88;
        7'h1D: return 7'd89;
        7'h20: return 7'd90;
        7'h21: return 7'd91;
        7'h22: return 7'd92;
        7'h24: return 7'd93;
        7'h2E: return 7'd94;
        7'h30: return 7'd95;
        7'h32: return 7'd96;
        7'h35: return 7'd97;
        7'h38: return 7'd98;
        7'h47: return 7'd99;
        7'h48: return 7'd100;
        7'h49: return 7'd101;
        7'h4B: return 7'd102;
        7'h4D: return 7'd103;
        7'h4F: return 7'd104;
        7'h63: return 7'd114;
        default: return CODE_UNKNOWN;
      endcase
    endfunction

    function void add_event(input logic [6:0] code, input logic rel, input logic lst);
      key_event_t ev;
      ev.key_code = code;
      ev.released = rel;
      ev.last     = lst;
      pending_events.push_back(ev);
    endfunction

    function void decode_byte(input logic [7:0] b);
      logic       rel;
      logic [6:0] idx;
      rel = b[7];
      idx = b[6:0];
      case (pstate)
        ST_E0: begin
          if (b == BYTE_2A || b == BYTE_B7) begin
            pstate = ST_PRTSC_1;
          end else begin
            pstate = ST_NORMAL;
            add_event(extended_key(idx), rel, 1'b1);
          end
        end
        ST_PRTSC_1: begin
          if (b == BYTE_E0) begin
            pstate = ST_E0_REPEAT;
          end else begin
            pstate = ST_NORMAL;
            add_event(single_key(idx), rel, 1'b1);
          end
        end
        ST_E0_REPEAT: begin
          pstate = ST_NORMAL;
          if (b == BYTE_37) add_event(CODE_PRINT_SCREEN, 1'b0, 1'b1);
          else if (b == BYTE_AA) add_event(CODE_PRINT_SCREEN, 1'b1, 1'b1);
        end
        ST_E1: if (b == BYTE_1D) pstate = ST_PAUSE_1;
        ST_PAUSE_1: if (b == BYTE_45) pstate = ST_PAUSE_2;
        ST_PAUSE_2: if (b == BYTE_E1) pstate = ST_E1_REPEAT;
        ST_E1_REPEAT: if (b == BYTE_9D) pstate = ST_PAUSE_3;
        ST_PAUSE_3: begin
          pstate = ST_NORMAL;
          if (b == BYTE_C5) begin
            add_event(CODE_PAUSE, 1'b0, 1'b0);
            add_event(CODE_PAUSE, 1'b1, 1'b1);
          end
        end
        default: begin
          if (b == BYTE_E0) begin
            pstate = ST_E0;
          end else if (b == BYTE_E1) begin
            pstate = ST_E1;
          end else begin
            pstate = ST_NORMAL;
            add_event(single_key(idx), rel, 1'b1);
          end
        end
      endcase
    endfunction

    function void match_event(input logic [6:0] code, input logic rel, input logic lst);
      key_event_t ev;
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected event: expected none, got code %0d released %0b last %0b",
                 $time, code, rel, lst);
        errors++;
        return;
      end
      ev = pending_events.pop_front();
      if (code !== ev.key_code) begin
        $display("%0t: key_code mismatch: expected %0d, got %0d", $time, ev.key_code, code);
        errors++;
      end
      if (rel !== ev.released) begin
        $display("%0t: released mismatch: expected %0b, got %0b", $time, ev.released, rel);
        errors++;
      end
      if (lst !== ev.last) begin
        $display("%0t: last mismatch: expected %0b, got %0b", $time, ev.last, lst);
        errors++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_scan_byte;
  logic       out_valid;
  logic       out_stall;
  logic [6:0] out_key_code;
  logic       out_released;
  logic       out_last;

  key_event_board sb;
  int tx_mode;
  int rx_mode;
  int rx_left;
  int rx_pick;
  int idle_cycles;
  int sent;

  ps2_set1_scancode_decoder_top DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_scan_byte (in_scan_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_key_code (out_key_code),
    .out_released (out_released),
    .out_last     (out_last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(negedge clk) begin
    if (rx_left > 0) begin
      rx_left = rx_left - 1;
    end else if (rx_mode == 0) begin
      out_stall <= 1'b0;
    end else begin
      rx_pick = $urandom_range(0, 99);
      if (rx_pick < 60) begin
        out_stall <= 1'b0;
        rx_left = $urandom_range(0, 4);
      end else if (rx_pick < 90) begin
        out_stall <= 1'b1;
        rx_left = $urandom_range(0, 2);
      end else begin
        out_stall <= 1'b1;
        rx_left = $urandom_range(10, 40);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      idle_cycles = idle_cycles + 1;
      if (in_valid && !in_stall) begin
        sb.decode_byte(in_scan_byte);
        idle_cycles = 0;
      end
      if (out_valid && !out_stall) begin
        sb.match_event(out_key_code, out_released, out_last);
        idle_cycles = 0;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[ps2_set1_scancode_decoder_top] ERROR");
        $finish;
      end
    end
  end

  function int pick_gap();
    int r;
    if (tx_mode == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function logic [7:0] rand_plain();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == BYTE_E0 || b == BYTE_E1);
    return b;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      in_scan_byte <= 8'($urandom_range(0, 255));
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_scan_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    logic [7:0] seq[$];
    logic [7:0] pat[$];
    logic [7:0] x;
    int pick;
    int k;
    int next_switch;
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_scan_byte = 8'h00;
    out_stall = 1'b0;
    tx_mode = 1;
    rx_mode = 1;
    rx_left = 0;
    idle_cycles = 0;
    sent = 0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    seq = '{8'h00, 8'h01, 8'h58, 8'hFF, 8'hD8,
            BYTE_E0, 8'h1C, BYTE_E0, BYTE_E0, BYTE_E0, BYTE_E1,
            BYTE_E0, BYTE_2A, 8'h1E,
            BYTE_E0, BYTE_2A, BYTE_E0, BYTE_37,
            BYTE_E1, BYTE_1D, BYTE_45, BYTE_E1, BYTE_9D, BYTE_C5};
    foreach (seq[i]) send_byte(seq[i]);
    drain();

    sent = 0;
    tx_mode = 0;
    rx_mode = 0;
    next_switch = 100;
    while (sent < RANDOM_ITEMS) begin
      if (sent >= next_switch) begin
        tx_mode = $urandom_range(0, 2);
        rx_mode = $urandom_range(0, 2);
        next_switch = next_switch + 100;
      end
      seq.delete();
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        seq.push_back(rand_plain());
      end else if (pick < 60) begin
        seq.push_back(BYTE_E0);
        seq.push_back(8'($urandom_range(0, 255)));
      end else if (pick < 68) begin
        seq = '{BYTE_E0, BYTE_2A, BYTE_E0, BYTE_37};
      end else if (pick < 76) begin
        seq = '{BYTE_E0, BYTE_B7, BYTE_E0, BYTE_AA};
      end else if (pick < 84) begin
        seq = '{BYTE_E1, BYTE_1D, BYTE_45, BYTE_E1, BYTE_9D, BYTE_C5};
      end else begin
        case ($urandom_range(0, 3))
          0: begin
            seq.push_back(BYTE_E0);
            seq.push_back($urandom_range(0, 1) ? BYTE_2A : BYTE_B7);
            seq.push_back(rand_plain());
          end
          1: begin
            seq.push_back(BYTE_E0);
            seq.push_back($urandom_range(0, 1) ? BYTE_2A : BYTE_B7);
            seq.push_back(BYTE_E0);
            seq.push_back(8'($urandom_range(0, 255)));
          end
          2: begin
            pat = '{BYTE_E1, BYTE_1D, BYTE_45, BYTE_E1, BYTE_9D, BYTE_C5};
            k = $urandom_range(1, 4);
            for (int i = 0; i < 6; i++) begin
              if (i == k) begin
                repeat ($urandom_range(1, 3)) begin
                  do x = 8'($urandom_range(0, 255)); while (x == pat[k]);
                  seq.push_back(x);
                end
              end
              seq.push_back(pat[i]);
            end
          end
          default: begin
            seq = '{BYTE_E1, BYTE_1D, BYTE_45, BYTE_E1, BYTE_9D};
            do x = 8'($urandom_range(0, 255)); while (x == BYTE_C5);
            seq.push_back(x);
          end
        endcase
      end
      foreach (seq[i]) send_byte(seq[i]);
      if (sent >= 400 && sent < 410) drain();
    end

    drain();
    repeat (8) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ps2_set1_scancode_decoder_top] OK");
    end else begin
      $display("[ps2_set1_scancode_decoder_top] ERROR");
    end
    $finish;
  end

endmodule
